// ===== sv/vlm_pkg.sv =====
`default_nettype none

package vlm_pkg;

    // Curve: eleven points, -5 dBFS (100%) down to -25 dBFS (0%)
    localparam int unsigned CurvePoints = 11;
    localparam int unsigned SegIdxW     = 4;
    localparam logic [6:0]  PctStep     = 7'd10;
    localparam logic [6:0]  PctFull     = 7'd100;

    // Interpolation divider: 17-bit dividend, 12-bit divisor, 8 quotient bits
    localparam int unsigned DivDW       = 17;
    localparam int unsigned DivSW       = 12;
    localparam int unsigned DivQW       = 8;
    localparam logic [DivSW-1:0] MsPerSecond = 12'd1000;
    localparam logic [DivDW-1:0] PctRound    = 17'd50;

    // Reciprocal multiplies: floor(x/1000) for x < 2^17, floor(x/100) for x < 2^15
    localparam logic [16:0] FallRecip = 17'd67109;
    localparam int unsigned FallShift = 26;
    localparam logic [12:0] LitRecip  = 13'd5243;
    localparam int unsigned LitShift  = 19;

    // Floor of x/5 as (x*205)>>10, exact for the four-fifths product
    localparam logic [17:0] RedScale = 18'd820;

    // Job queue between classifier and ballistics engine
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgReleaseRate  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSegmentCount = 2'd1;

    typedef struct packed {
        logic [15:0] level;
        logic [15:0] gap_ms;
    } t_in_item;

    typedef struct packed {
        logic [6:0] display_percent;
        logic [7:0] lit_count;
        logic [7:0] first_red_segment;
        logic       red_lit;
    } t_out_item;

    typedef struct packed {
        logic [9:0] release_rate;
        logic [7:0] segment_count;
    } t_cfg;

    // Classified reading: base percent plus optional interpolation division
    typedef struct packed {
        logic [6:0]       base_pct;
        logic             needs_div;
        logic [DivDW-1:0] dividend;
        logic [DivSW-1:0] span;
        logic [15:0]      gap_ms;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [DivDW-1:0] dividend;
        logic [DivSW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DivQW-1:0] quot;
    } t_div_rsp;

    function automatic logic [15:0] curve_level(input logic [SegIdxW-1:0] idx);
        logic [15:0] lv;
        case (idx)
            4'd0:    lv = 16'd18426;
            4'd1:    lv = 16'd14640;
            4'd2:    lv = 16'd11626;
            4'd3:    lv = 16'd9238;
            4'd4:    lv = 16'd7338;
            4'd5:    lv = 16'd5828;
            4'd6:    lv = 16'd4630;
            4'd7:    lv = 16'd3677;
            4'd8:    lv = 16'd2921;
            4'd9:    lv = 16'd2320;
            4'd10:   lv = 16'd1843;
            default: lv = 16'd0;
        endcase
        return lv;
    endfunction

    function automatic logic [6:0] curve_pct(input logic [SegIdxW-1:0] idx);
        return 7'(PctFull - 7'(idx) * PctStep);
    endfunction

endpackage

`default_nettype wire

// ===== sv/vlm_front.sv =====
`default_nettype none

module vlm_front (
    input  wire logic             i_in_valid,
    input  wire vlm_pkg::t_in_item i_in_item,
    input  wire logic             i_q_full,
    output logic                  o_in_ready,
    output logic                  o_push,
    output vlm_pkg::t_job         o_job
);

    logic [vlm_pkg::SegIdxW-1:0] seg;
    logic [15:0]                 lo_lv;
    logic [15:0]                 hi_lv;
    logic [15:0]                 into;
    logic [15:0]                 span_w;
    logic [18:0]                 into10;

    // Accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Find the first curve point that the level lies above
    always_comb begin
        seg = vlm_pkg::SegIdxW'(vlm_pkg::CurvePoints - 1);
        for (int k = vlm_pkg::CurvePoints - 1; k >= 1; k--) begin
            if (i_in_item.level > vlm_pkg::curve_level(vlm_pkg::SegIdxW'(k))) begin
                seg = vlm_pkg::SegIdxW'(k);
            end
        end
    end

    assign lo_lv  = vlm_pkg::curve_level(seg);
    assign hi_lv  = vlm_pkg::curve_level(seg - 4'd1);
    assign into   = i_in_item.level - lo_lv;
    assign span_w = hi_lv - lo_lv;
    assign into10 = {into, 3'b000} + {2'b00, into, 1'b0};

    // Classify: loud clamp, quiet floor, or interpolate within a segment
    always_comb begin
        o_job.gap_ms     = i_in_item.gap_ms;
        o_job.dividend   = into10[vlm_pkg::DivDW-1:0];
        o_job.span       = span_w[vlm_pkg::DivSW-1:0];
        if (i_in_item.level >= vlm_pkg::curve_level(4'd0)) begin
            o_job.base_pct  = vlm_pkg::PctFull;
            o_job.needs_div = 1'b0;
        end else if (i_in_item.level <=
                     vlm_pkg::curve_level(vlm_pkg::SegIdxW'(vlm_pkg::CurvePoints - 1))) begin
            o_job.base_pct  = 7'd0;
            o_job.needs_div = 1'b0;
        end else begin
            o_job.base_pct  = vlm_pkg::curve_pct(seg);
            o_job.needs_div = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vlm_queue.sv =====
`default_nettype none

module vlm_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire vlm_pkg::t_job i_job,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_empty,
    output vlm_pkg::t_job     o_job
);

    vlm_pkg::t_job                 r_mem [vlm_pkg::QueueDepth];
    logic [vlm_pkg::QueuePtrW-1:0] r_wr_ptr;
    logic [vlm_pkg::QueuePtrW-1:0] r_rd_ptr;
    logic [vlm_pkg::QueuePtrW:0]   r_count;

    assign o_full  = (r_count == (vlm_pkg::QueuePtrW+1)'(vlm_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Store items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue pop while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance");

endmodule

`default_nettype wire

// ===== sv/vlm_div.sv =====
`default_nettype none

module vlm_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire vlm_pkg::t_div_req i_req,
    output vlm_pkg::t_div_rsp     o_rsp
);

    localparam int unsigned TrialW = vlm_pkg::DivSW + vlm_pkg::DivQW;

    logic [vlm_pkg::DivDW-1:0]       r_rem;
    logic [vlm_pkg::DivSW-1:0]       r_dvsr;
    logic [$clog2(vlm_pkg::DivQW)-1:0] r_step;
    logic                            r_busy;
    logic                            r_done;
    logic [vlm_pkg::DivQW-1:0]       r_quot;
    logic [TrialW-1:0]               trial;
    logic                            fits;

    // Divisor aligned to the current quotient bit
    assign trial = TrialW'(r_dvsr) << r_step;
    assign fits  = TrialW'(r_rem) >= trial;

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    // Restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_step == '0);
            if (i_req.start) begin
                r_rem  <= i_req.dividend;
                r_dvsr <= i_req.divisor;
                r_step <= '1;
                r_quot <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem         <= r_rem - trial[vlm_pkg::DivDW-1:0];
                    r_quot[r_step] <= 1'b1;
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider restarted while busy");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy) else $error("divider done without a run");
    a_nonzero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> i_req.divisor != '0) else $error("divider started with zero");

endmodule

`default_nettype wire

// ===== sv/vlm_back.sv =====
`default_nettype none

module vlm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vlm_pkg::t_cfg     i_cfg,
    input  wire logic              i_empty,
    input  wire vlm_pkg::t_job     i_job,
    output logic                   o_pop,
    output vlm_pkg::t_div_req      o_div_req,
    input  wire vlm_pkg::t_div_rsp i_div_rsp,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output vlm_pkg::t_out_item     o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TGT_WAIT,
        S_MUL,
        S_FALL,
        S_FALL_WAIT,
        S_LIT,
        S_LIT_WAIT,
        S_OUT
    } t_state;

    t_state                    r_state;
    vlm_pkg::t_job             r_job;
    logic [6:0]                r_target;
    logic [6:0]                r_shown;
    logic [25:0]               r_prod;
    logic [6:0]                r_fall;
    logic [vlm_pkg::DivDW-1:0] r_lit_num;
    logic [7:0]                r_lit;
    logic                      r_div_start;
    logic [vlm_pkg::DivDW-1:0] r_div_dividend;
    logic [vlm_pkg::DivSW-1:0] r_div_divisor;
    logic                      r_out_valid;
    vlm_pkg::t_out_item        r_out;

    logic [25:0]               prod;
    logic [25:0]               shown_ms;
    logic [vlm_pkg::DivDW-1:0] lit_num;
    logic [33:0]               fall_scaled;
    logic [6:0]                fall_q;
    logic [29:0]               lit_scaled;
    logic [7:0]                lit_quot;
    logic [17:0]               red_prod;
    logic [7:0]                first_red;
    logic [6:0]                diff;
    logic [7:0]                quot_lit;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign o_div_req.start    = r_div_start;
    assign o_div_req.dividend = r_div_dividend;
    assign o_div_req.divisor  = r_div_divisor;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Datapath helpers
    assign prod      = 26'(r_job.gap_ms) * 26'(i_cfg.release_rate);
    assign shown_ms  = 26'(17'(r_shown) * 17'(vlm_pkg::MsPerSecond));
    assign lit_num   = vlm_pkg::DivDW'(r_shown) * vlm_pkg::DivDW'(i_cfg.segment_count)
                       + vlm_pkg::PctRound;
    assign red_prod  = 18'(i_cfg.segment_count) * vlm_pkg::RedScale;
    assign first_red = red_prod[17:10];

    // Fall in percent: product over 1000 by reciprocal multiply
    assign fall_scaled = 34'(r_prod[vlm_pkg::DivDW-1:0]) * 34'(vlm_pkg::FallRecip);
    assign fall_q      = fall_scaled[vlm_pkg::FallShift +: 7];
    assign diff        = r_shown - r_fall;

    // Rounded segment count: numerator over 100 by reciprocal multiply
    assign lit_scaled  = 30'(r_lit_num) * 30'(vlm_pkg::LitRecip);
    assign lit_quot    = lit_scaled[vlm_pkg::LitShift +: 8];
    assign quot_lit    = (lit_quot == '0) ? 8'd1 :
                         (lit_quot > i_cfg.segment_count) ? i_cfg.segment_count :
                         lit_quot;

    // Sequence target, ballistics, segment count and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shown     <= 7'd0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_IDLE) && !i_empty && i_job.needs_div;
            // Drop the result once taken, unless a new one is loaded
            if (i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        if (i_job.needs_div) begin
                            r_div_dividend <= i_job.dividend;
                            r_div_divisor  <= i_job.span;
                            r_state        <= S_TGT_WAIT;
                        end else begin
                            r_target <= i_job.base_pct;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_TGT_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_target <= r_job.base_pct + i_div_rsp.quot[6:0];
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= prod;
                    r_state <= S_FALL;
                end
                S_FALL: begin
                    // Attack jumps to target; a fall past the target stops there
                    if (r_target >= r_shown || r_prod >= shown_ms) begin
                        r_shown <= r_target;
                        r_state <= S_LIT;
                    end else begin
                        r_fall  <= fall_q;
                        r_state <= S_FALL_WAIT;
                    end
                end
                S_FALL_WAIT: begin
                    r_shown <= (diff < r_target) ? r_target : diff;
                    r_state <= S_LIT;
                end
                S_LIT: begin
                    if (i_cfg.segment_count == 8'd0 || r_shown == 7'd0) begin
                        r_lit   <= 8'd0;
                        r_state <= S_OUT;
                    end else if (r_shown >= vlm_pkg::PctFull) begin
                        r_lit   <= i_cfg.segment_count;
                        r_state <= S_OUT;
                    end else begin
                        r_lit_num <= lit_num;
                        r_state   <= S_LIT_WAIT;
                    end
                end
                S_LIT_WAIT: begin
                    r_lit   <= quot_lit;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Load the output register once it is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out.display_percent   <= r_shown;
                        r_out.lit_count         <= r_lit;
                        r_out.first_red_segment <= first_red;
                        r_out.red_lit           <= (i_cfg.segment_count != 8'd0) &&
                                                   (r_lit != 8'd0) &&
                                                   ((r_lit - 8'd1) >= first_red);
                        r_out_valid             <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> r_state == S_TGT_WAIT)
        else $error("divider result arrived outside a wait state");
    a_shown_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LIT |-> r_shown <= vlm_pkg::PctFull)
        else $error("displayed percent out of range");
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result loaded outside the output state");
    a_lit_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.lit_count <= i_cfg.segment_count)
        else $error("lit count exceeds segment count");

endmodule

`default_nettype wire

// ===== sv/vu_level_meter_unit.sv =====
// VU level meter: each item carries an RMS level and the milliseconds since
// the previous reading; each item yields exactly one result with the bar
// height after attack/release ballistics, lit segment count, red zone start
// and red flag. A classifier maps the level onto the dB curve at acceptance
// and writes a job into a two-entry queue, so up to two more items are taken
// while the engine works. For each item the engine takes a job, scales the
// release, compares, counts segments and loads the result, waiting while
// the previous result still waits for i_out_ready. The 8-step restoring
// divider interpolates first when the level lies between two curve points;
// a falling bar and a rounded lit count pass through S_FALL_WAIT and
// S_LIT_WAIT, both done by reciprocal multiplies. Writes to release_rate
// (index 0) and segment_count (index 1) are always accepted and must only
// be made while no item is in flight.
`default_nettype none

module vu_level_meter_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire vlm_pkg::t_in_item            i_in_item,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output vlm_pkg::t_out_item                o_out_item,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [vlm_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [9:0]                   i_cfg_data
);

    vlm_pkg::t_cfg     r_cfg;
    vlm_pkg::t_job     front_job;
    vlm_pkg::t_job     q_job;
    vlm_pkg::t_div_req div_req;
    vlm_pkg::t_div_rsp div_rsp;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_rate  <= 10'd100;
            r_cfg.segment_count <= 8'd20;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vlm_pkg::CfgReleaseRate:  r_cfg.release_rate  <= i_cfg_data;
                vlm_pkg::CfgSegmentCount: r_cfg.segment_count <= i_cfg_data[7:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    vlm_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_job      (front_job)
    );

    vlm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    vlm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    vlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (q_empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_vu_level_meter_unit.sv =====
`timescale 1ns / 100ps

module tb_vu_level_meter_unit;

    localparam int unsigned WatchdogLimit = 4000;
    localparam int unsigned DrainCycles   = 40;
    localparam int unsigned ItemsPerPhase = 660;
    localparam int unsigned ItemsPerCfg   = 165;

    // Block ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    vlm_pkg::t_in_item             i_in_item = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    vlm_pkg::t_out_item            o_out_item;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [vlm_pkg::CfgIdxW-1:0]   i_cfg_index = '0;
    logic [9:0]                    i_cfg_data = '0;

    // Meter state as the testbench sees it
    int unsigned          bar_pct;
    int unsigned          rate_reg;
    int unsigned          seg_reg;

    vlm_pkg::t_out_item   expected_readouts[$];
    vlm_pkg::t_out_item   want;
    int unsigned          mismatch_count = 0;

    // Idle and stall chances in percent, plus an explicit output hold-off
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          out_hold_left = 0;

    vu_level_meter_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // dB curve breakpoints, loudest first; percent drops by 10 per point
    function automatic int unsigned breakpoint_level(input int unsigned k);
        int unsigned lv;
        case (k)
            0:       lv = 18426;
            1:       lv = 14640;
            2:       lv = 11626;
            3:       lv = 9238;
            4:       lv = 7338;
            5:       lv = 5828;
            6:       lv = 4630;
            7:       lv = 3677;
            8:       lv = 2921;
            9:       lv = 2320;
            default: lv = 1843;
        endcase
        return lv;
    endfunction

    function automatic int unsigned level_to_target(input int unsigned lv);
        int unsigned k;
        int unsigned hi;
        int unsigned lo;
        if (lv >= breakpoint_level(0)) return 100;
        if (lv <= breakpoint_level(10)) return 0;
        for (k = 1; k <= 10; k++) begin
            hi = breakpoint_level(k - 1);
            lo = breakpoint_level(k);
            if (lv > lo) return (100 - 10 * k) + ((lv - lo) * 10) / (hi - lo);
        end
        return 0;
    endfunction

    // Apply attack/release to the bar and derive the segment view
    function automatic vlm_pkg::t_out_item predict_readout(input vlm_pkg::t_in_item rd);
        vlm_pkg::t_out_item res;
        int unsigned target;
        int unsigned fall;
        int unsigned lit;
        int unsigned red_start;
        target = level_to_target(32'(rd.level));
        if (target >= bar_pct) begin
            bar_pct = target;
        end else begin
            fall = (32'(rd.gap_ms) * rate_reg) / 1000;
            if (fall >= bar_pct || bar_pct - fall < target) bar_pct = target;
            else bar_pct = bar_pct - fall;
        end
        bar_pct = bar_pct & 32'h7F;
        if (seg_reg == 0 || bar_pct == 0) begin
            lit = 0;
        end else if (bar_pct >= 100) begin
            lit = seg_reg;
        end else begin
            lit = (bar_pct * seg_reg + 50) / 100;
            if (lit == 0) lit = 1;
            if (lit > seg_reg) lit = seg_reg;
        end
        red_start = (seg_reg * 4) / 5;
        res.display_percent   = 7'(bar_pct);
        res.lit_count         = 8'(lit);
        res.first_red_segment = 8'(red_start);
        res.red_lit           = (seg_reg != 0 && lit != 0 && lit - 1 >= red_start);
        return res;
    endfunction

    function automatic vlm_pkg::t_in_item make_reading(input int unsigned lv,
                                                       input int unsigned ms);
        vlm_pkg::t_in_item rd;
        rd.level  = 16'(lv);
        rd.gap_ms = 16'(ms);
        return rd;
    endfunction

    // Random reading: mostly inside the curve, some loud, quiet and edge values
    function automatic vlm_pkg::t_in_item random_reading();
        int lv;
        int ms;
        case ($urandom_range(9))
            0:       lv = $urandom_range(65535);
            1:       lv = $urandom_range(65535, 18426);
            2:       lv = $urandom_range(1843);
            3:       lv = int'(breakpoint_level($urandom_range(10))) + $urandom_range(4) - 2;
            default: lv = $urandom_range(18425, 1844);
        endcase
        case ($urandom_range(9))
            0:       ms = $urandom_range(65535);
            1:       ms = 0;
            2:       ms = 65535;
            default: ms = $urandom_range(300);
        endcase
        return make_reading(lv, ms);
    endfunction

    // Offer one item, hold it until taken, then record its expected readout
    task automatic send_reading(input vlm_pkg::t_in_item rd);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= rd;
        do @(posedge i_clk); while (!o_in_ready);
        expected_readouts.push_back(predict_readout(rd));
    endtask

    task automatic send_level(input int unsigned lv, input int unsigned ms);
        send_reading(make_reading(lv, ms));
    endtask

    // Drop valid and wait until every readout has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [vlm_pkg::CfgIdxW-1:0] idx,
                             input int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 10'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == vlm_pkg::CfgReleaseRate) rate_reg = data & 32'h3FF;
        else if (idx == vlm_pkg::CfgSegmentCount) seg_reg = data & 32'hFF;
    endtask

    task automatic set_config(input int unsigned rate, input int unsigned segs);
        drain();
        write_reg(vlm_pkg::CfgReleaseRate, rate);
        write_reg(vlm_pkg::CfgSegmentCount, segs);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_random_config();
        int unsigned rate;
        int unsigned segs;
        case ($urandom_range(5))
            0:       rate = 0;
            1:       rate = 1000;
            2:       rate = 1023;
            3:       rate = $urandom_range(1023, 1001);
            default: rate = $urandom_range(1023);
        endcase
        case ($urandom_range(5))
            0:       segs = 0;
            1:       segs = 1;
            2:       segs = 255;
            default: segs = $urandom_range(255);
        endcase
        set_config(rate, segs);
    endtask

    // Every breakpoint, both clamps and the values just inside them
    task automatic test_curve_points();
        int unsigned k;
        send_level(65535, 0);
        send_level(18426, 0);
        send_level(18425, 65535);
        for (k = 1; k <= 9; k++) send_level(breakpoint_level(k), 65535);
        send_level(1844, 65535);
        send_level(1843, 0);
        send_level(0, 0);
    endtask

    // Release steps, a fall that stops at the target and one past zero
    task automatic test_release_fall();
        send_level(65535, 0);
        send_level(0, 100);
        send_level(0, 899);
        send_level(0, 10);
        send_level(65535, 0);
        send_level(9238, 200);
        send_level(9238, 65535);
    endtask

    // No segments, a single segment and the widest bar
    task automatic test_segment_edges();
        set_config(100, 0);
        send_level(65535, 0);
        send_level(0, 65535);
        set_config(100, 1);
        send_level(1891, 0);
        set_config(100, 255);
        send_level(65535, 0);
        send_level(1891, 65535);
    endtask

    // Rate above the nominal range, then a frozen bar
    task automatic test_fast_release();
        set_config(1023, 20);
        send_level(65535, 0);
        send_level(0, 50);
        set_config(0, 20);
        send_level(0, 65535);
    endtask

    // Hold the output off while the sender keeps pushing items
    task automatic test_output_stall();
        int unsigned n;
        set_config(100, 20);
        send_idle_pct = 0;
        out_hold_left = 300;
        for (n = 0; n < 24; n++) send_reading(random_reading());
    endtask

    task automatic test_random_readings(input int unsigned sidle, input int unsigned rstall);
        int unsigned n;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (n = 0; n < ItemsPerPhase; n++) begin
            if (n % ItemsPerCfg == 0) set_random_config();
            send_reading(random_reading());
        end
    endtask

    // Output side: random backpressure, or a counted hold-off when asked
    always @(posedge i_clk) begin
        if (out_hold_left != 0) begin
            i_out_ready   <= 1'b0;
            out_hold_left <= out_hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each readout with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readouts.size() == 0) begin
                $error("readout with no expectation pending");
                mismatch_count++;
            end else begin
                want = expected_readouts.pop_front();
                if (o_out_item.display_percent !== want.display_percent) begin
                    $error("display_percent: expected %0d, got %0d",
                           want.display_percent, o_out_item.display_percent);
                    mismatch_count++;
                end
                if (o_out_item.lit_count !== want.lit_count) begin
                    $error("lit_count: expected %0d, got %0d",
                           want.lit_count, o_out_item.lit_count);
                    mismatch_count++;
                end
                if (o_out_item.first_red_segment !== want.first_red_segment) begin
                    $error("first_red_segment: expected %0d, got %0d",
                           want.first_red_segment, o_out_item.first_red_segment);
                    mismatch_count++;
                end
                if (o_out_item.red_lit !== want.red_lit) begin
                    $error("red_lit: expected %0d, got %0d",
                           want.red_lit, o_out_item.red_lit);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run if no item moves on any channel for too long
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        bar_pct  = 0;
        rate_reg = 100;
        seg_reg  = 20;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 6;
        recv_stall_pct = 67;
        test_curve_points();
        test_release_fall();
        test_segment_edges();
        test_fast_release();
        test_output_stall();

        test_random_readings(6, 67);
        test_random_readings(67, 6);
        test_random_readings(0, 0);

        drain();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== vu_level_meter_unit.f =====
sv/vlm_pkg.sv
sv/vlm_front.sv
sv/vlm_queue.sv
sv/vlm_div.sv
sv/vlm_back.sv
sv/vu_level_meter_unit.sv
tb/sv/tb_vu_level_meter_unit.sv
